[hdl/ppdq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ppdq_pkg;

	localparam int POOL_ENTRIES_DEF = 16;
	localparam int FIFO_DEPTH_DEF   = 8;

	localparam int OP_W     = 3;
	localparam int HANDLE_W = 4;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int PCOUNT_W = 5;
	localparam int QCOUNT_W = 4;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 3'd0,
		OP_FREE  = 3'd1,
		OP_PUSH  = 3'd2,
		OP_PEEK  = 3'd3,
		OP_POP   = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_OVERFLOW  = 3'd2,
		STAT_EXHAUSTED = 3'd3,
		STAT_OVERFREE  = 3'd4
	} status_t;

	localparam logic [MODE_W-1:0] DROP_OLDEST   = 2'd1;
	localparam logic [MODE_W-1:0] DROP_INCOMING = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

`default_nettype wire

[hdl/ppdq_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ppdq_cmd_if
	import ppdq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [HANDLE_W-1:0] handle;
	logic [MODE_W-1:0]   drop_mode;

	modport source (output valid, output operation, output handle, output drop_mode,
		input ready);
	modport sink (input valid, input operation, input handle, input drop_mode,
		output ready);
endinterface

`default_nettype wire

[hdl/ppdq_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ppdq_rsp_if
	import ppdq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] result_handle;
	logic [PCOUNT_W-1:0] pool_free_count;
	logic [QCOUNT_W-1:0] queue_count;

	modport source (output valid, output status, output result_handle,
		output pool_free_count, output queue_count, input ready);
	modport sink (input valid, input status, input result_handle,
		input pool_free_count, input queue_count, output ready);
endinterface

`default_nettype wire

[hdl/ppdq_link_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ppdq_link_ram
	import ppdq_pkg::*;
#(
	parameter int ENTRIES = POOL_ENTRIES_DEF,
	parameter int LINK_W  = $clog2(POOL_ENTRIES_DEF + 1),
	parameter int IDX_W   = (POOL_ENTRIES_DEF > 1) ? $clog2(POOL_ENTRIES_DEF) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_addr,
	output logic      [LINK_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_addr,
	input  wire logic [LINK_W-1:0] wr_data
);

	logic [LINK_W-1:0]  mem [ENTRIES];
	logic [ENTRIES-1:0] written_q;
	logic [LINK_W-1:0]  data_s1;
	logic [IDX_W-1:0]   addr_s1;
	logic               written_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			written_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				written_s1 <= written_q[rd_addr];
			end
		end
	end

	// untouched entry i links to i-1, entry 0 to null
	always_comb begin
		if (written_s1) begin
			rd_data = data_s1;
		end else if (addr_s1 == '0) begin
			rd_data = LINK_W'(ENTRIES);
		end else begin
			rd_data = LINK_W'(addr_s1) - 1'b1;
		end
	end

endmodule

`default_nettype wire

[hdl/ppdq_slot_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ppdq_slot_ram
	import ppdq_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF,
	parameter int IDX_W = (FIFO_DEPTH_DEF > 1) ? $clog2(FIFO_DEPTH_DEF) : 1
) (
	input  wire logic                clk,
	input  wire logic                rd_en,
	input  wire logic [IDX_W-1:0]    rd_addr,
	output logic      [HANDLE_W-1:0] rd_data,
	input  wire logic                wr_en,
	input  wire logic [IDX_W-1:0]    wr_addr,
	input  wire logic [HANDLE_W-1:0] wr_data
);

	logic [HANDLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hdl/packet_pool_with_drop_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  payload
// cmd      in   operation[2:0], handle[3:0], drop_mode[1:0]
// rsp      out  status[2:0], result_handle[3:0], pool_free_count[4:0], queue_count[3:0]
//
// a request is taken in the idle state, where the link and slot memories are read
// at the current pool head and queue front; ST_EXEC then modifies and writes back.
// reset gives a full pool and an empty queue at once; no clearing pass.
// a result waits in the output register; a stalled rsp holds the block in
// its write-back cycle, while the first request after it is still accepted.

module packet_pool_with_drop_queue_unit
	import ppdq_pkg::*;
#(
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
	parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	ppdq_cmd_if.sink  cmd,
	ppdq_rsp_if.source rsp
);

	localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
	localparam int PIDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int FIDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	state_t state_q, state_d;

	logic [LINK_W-1:0]   top_q, top_d;
	logic [LINK_W-1:0]   total_q, total_d;
	logic [FIDX_W-1:0]   front_q, front_d;
	logic [FCNT_W-1:0]   fill_q, fill_d;

	logic [OP_W-1:0]     op_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [MODE_W-1:0]   mode_q;

	logic                rsp_valid_q;
	status_t             status_q, status_d;
	logic [HANDLE_W-1:0] res_q, res_d;

	logic                accept;
	logic                finish;

	logic                link_rd_en;
	logic [LINK_W-1:0]   link_rd_data;
	logic                link_wr_en;
	logic [PIDX_W-1:0]   link_wr_addr;
	logic [LINK_W-1:0]   link_wr_data;

	logic [HANDLE_W-1:0] slot_rd_data;
	logic                slot_wr_en;
	logic [FIDX_W-1:0]   slot_wr_addr;

	logic [FIDX_W:0]     tail_sum;
	logic [FIDX_W-1:0]   tail;
	logic [FIDX_W-1:0]   front_next;
	logic                pool_full;
	logic                fifo_full;
	logic                fifo_empty;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign finish    = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);

	// head may be null, then no read is needed
	assign link_rd_en = accept && (32'(top_q) < POOL_ENTRIES);

	ppdq_link_ram #(
		.ENTRIES (POOL_ENTRIES),
		.LINK_W  (LINK_W),
		.IDX_W   (PIDX_W)
	) u_link_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (link_rd_en),
		.rd_addr (PIDX_W'(top_q)),
		.rd_data (link_rd_data),
		.wr_en   (link_wr_en),
		.wr_addr (link_wr_addr),
		.wr_data (link_wr_data)
	);

	ppdq_slot_ram #(
		.DEPTH (FIFO_DEPTH),
		.IDX_W (FIDX_W)
	) u_slot_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (front_q),
		.rd_data (slot_rd_data),
		.wr_en   (slot_wr_en),
		.wr_addr (slot_wr_addr),
		.wr_data (handle_q)
	);

	assign tail_sum   = (FIDX_W+1)'(front_q) + (FIDX_W+1)'(fill_q);
	assign tail       = (tail_sum >= (FIDX_W+1)'(FIFO_DEPTH)) ?
		FIDX_W'(tail_sum - (FIDX_W+1)'(FIFO_DEPTH)) : FIDX_W'(tail_sum);
	assign front_next = (32'(front_q) == FIFO_DEPTH - 1) ? '0 : front_q + 1'b1;
	assign pool_full  = (total_q >= LINK_W'(POOL_ENTRIES));
	assign fifo_full  = (fill_q >= FCNT_W'(FIFO_DEPTH));
	assign fifo_empty = (fill_q == '0);

	always_comb begin
		state_d      = state_q;
		top_d        = top_q;
		total_d      = total_q;
		front_d      = front_q;
		fill_d       = fill_q;
		status_d     = STAT_OK;
		res_d        = '0;
		link_wr_en   = 1'b0;
		link_wr_addr = PIDX_W'(handle_q);
		link_wr_data = top_q;
		slot_wr_en   = 1'b0;
		slot_wr_addr = tail;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (finish) begin
					state_d = ST_IDLE;
					case (op_q)
						OP_ALLOC: begin
							if (total_q == '0 || 32'(top_q) >= POOL_ENTRIES) begin
								status_d = STAT_EXHAUSTED;
							end else begin
								res_d        = HANDLE_W'(top_q);
								top_d        = link_rd_data;
								link_wr_en   = 1'b1;
								link_wr_addr = PIDX_W'(top_q);
								link_wr_data = LINK_W'(POOL_ENTRIES);
								total_d      = total_q - 1'b1;
							end
						end
						OP_FREE: begin
							if (pool_full || 32'(handle_q) >= POOL_ENTRIES) begin
								status_d = STAT_OVERFREE;
							end else begin
								link_wr_en = 1'b1;
								top_d      = LINK_W'(handle_q);
								total_d    = total_q + 1'b1;
							end
						end
						OP_PUSH: begin
							if (!fifo_full) begin
								slot_wr_en = 1'b1;
								fill_d     = fill_q + 1'b1;
							end else if (mode_q == DROP_OLDEST) begin
								if (pool_full || 32'(slot_rd_data) >= POOL_ENTRIES) begin
									status_d = STAT_OVERFREE;
								end else begin
									// oldest goes back to the pool, new one takes its slot
									link_wr_en   = 1'b1;
									link_wr_addr = PIDX_W'(slot_rd_data);
									top_d        = LINK_W'(slot_rd_data);
									total_d      = total_q + 1'b1;
									slot_wr_en   = 1'b1;
									slot_wr_addr = front_q;
									front_d      = front_next;
								end
							end else if (mode_q == DROP_INCOMING) begin
								if (pool_full || 32'(handle_q) >= POOL_ENTRIES) begin
									status_d = STAT_OVERFREE;
								end else begin
									link_wr_en = 1'b1;
									top_d      = LINK_W'(handle_q);
									total_d    = total_q + 1'b1;
								end
							end else begin
								status_d = STAT_OVERFLOW;
							end
						end
						OP_PEEK: begin
							if (fifo_empty) begin
								status_d = STAT_EMPTY;
							end else begin
								res_d = slot_rd_data;
							end
						end
						OP_POP: begin
							if (fifo_empty) begin
								status_d = STAT_EMPTY;
							end else begin
								res_d  = slot_rd_data;
								fill_d = fill_q - 1'b1;
								// drained queue restarts at slot zero
								front_d = (fill_q == FCNT_W'(1)) ? '0 : front_next;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_q       <= LINK_W'(POOL_ENTRIES - 1);
			total_q     <= LINK_W'(POOL_ENTRIES);
			front_q     <= '0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			total_q <= total_d;
			front_q <= front_d;
			fill_q  <= fill_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= cmd.operation;
			handle_q <= cmd.handle;
			mode_q   <= cmd.drop_mode;
		end
		if (finish) begin
			status_q <= status_d;
			res_q    <= res_d;
		end
	end

	logic [PCOUNT_W-1:0] pcount_q;
	logic [QCOUNT_W-1:0] qcount_q;

	always_ff @(posedge clk) begin
		if (finish) begin
			pcount_q <= PCOUNT_W'(total_d);
			qcount_q <= QCOUNT_W'(fill_d);
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.result_handle   = res_q;
	assign rsp.pool_free_count = pcount_q;
	assign rsp.queue_count     = qcount_q;

endmodule

`default_nettype wire

[test/packet_pool_with_drop_queue_unit_test.sv]
`timescale 1ns / 1ps

module packet_pool_with_drop_queue_unit_test;
	import ppdq_pkg::*;

	localparam int POOL_N     = POOL_ENTRIES_DEF;
	localparam int RING_N     = FIFO_DEPTH_DEF;
	localparam int NULL_LINK  = POOL_N;
	localparam int POOL_IDX_W = (POOL_N > 1) ? $clog2(POOL_N) : 1;
	localparam int RING_IDX_W = (RING_N > 1) ? $clog2(RING_N) : 1;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

	localparam logic [MODE_W-1:0] DROP_REPORT = 2'd0;
	localparam logic [MODE_W-1:0] DROP_SPARE  = 2'd3;

	localparam int RANDOM_ITEMS  = 1850;
	localparam int DRAIN_POINT   = 1100;
	localparam int CALM_TX_FIRST = 700;
	localparam int CALM_TX_LAST  = 1000;
	localparam int CALM_RX_FIRST = 1300;
	localparam int CALM_RX_LAST  = 1600;
	localparam int LONG_STALL_AT = 400;
	localparam int LONG_STALL    = 250;
	localparam int IDLE_PCT      = 26;

	typedef enum int {
		MIX_EVEN,
		MIX_ALLOC,
		MIX_FREE,
		MIX_PUSH,
		MIX_POP
	} op_mix_t;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [HANDLE_W-1:0] handle;
		logic [MODE_W-1:0]   drop_mode;
	} pool_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] result_handle;
		logic [PCOUNT_W-1:0] free_count;
		logic [QCOUNT_W-1:0] queue_count;
	} pool_rsp_t;

	logic clk;
	logic arst_n;

	ppdq_cmd_if cmd_ch ();
	ppdq_rsp_if rsp_ch ();

	packet_pool_with_drop_queue_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the pool and the ring
	logic [PCOUNT_W-1:0]   pool_link [POOL_N];
	logic [PCOUNT_W-1:0]   pool_head;
	logic [PCOUNT_W-1:0]   pool_avail;
	logic [HANDLE_W-1:0]   ring_slot [RING_N];
	logic [RING_IDX_W-1:0] ring_front;
	logic [QCOUNT_W-1:0]   ring_fill;

	pool_req_t pending_reqs [$];
	pool_rsp_t expected_rsps [$];

	int  accepted_total;
	int  results_seen;
	int  total_items;
	int  directed_count;
	int  errors;
	bit  cmd_taken;
	int  stall_left;
	bit  long_stall_done;

	function automatic void reset_shadow();
		for (int i = 0; i < POOL_N; i++)
			pool_link[POOL_IDX_W'(i)] = (i == 0) ? PCOUNT_W'(NULL_LINK) : PCOUNT_W'(i - 1);
		for (int i = 0; i < RING_N; i++)
			ring_slot[RING_IDX_W'(i)] = '0;
		pool_head  = PCOUNT_W'(POOL_N - 1);
		pool_avail = PCOUNT_W'(POOL_N);
		ring_front = '0;
		ring_fill  = '0;
	endfunction

	function automatic bit pool_return(logic [HANDLE_W-1:0] h);
		if (pool_avail >= POOL_N || h >= POOL_N)
			return 1'b0;
		pool_link[h] = pool_head;
		pool_head    = PCOUNT_W'(h);
		pool_avail   = pool_avail + 1'b1;
		return 1'b1;
	endfunction

	function automatic logic [HANDLE_W-1:0] ring_take();
		logic [HANDLE_W-1:0] h;
		h = ring_slot[ring_front];
		ring_fill = ring_fill - 1'b1;
		if (ring_fill == 0)
			ring_front = '0;
		else
			ring_front = RING_IDX_W'((int'(ring_front) + 1) % RING_N);
		return h;
	endfunction

	function automatic void ring_append(logic [HANDLE_W-1:0] h);
		logic [RING_IDX_W-1:0] tail;
		tail = RING_IDX_W'((int'(ring_front) + int'(ring_fill)) % RING_N);
		ring_slot[tail] = h;
		ring_fill = ring_fill + 1'b1;
	endfunction

	function automatic pool_rsp_t apply_pool_op(pool_req_t r);
		pool_rsp_t           o;
		logic [HANDLE_W-1:0] oldest;
		o.status        = STAT_OK;
		o.result_handle = '0;
		case (r.operation)
			OP_ALLOC: begin
				if (pool_avail == 0 || pool_head >= POOL_N) begin
					o.status = STAT_EXHAUSTED;
				end else begin
					o.result_handle      = pool_head[HANDLE_W-1:0];
					pool_head            = pool_link[o.result_handle];
					pool_link[o.result_handle] = PCOUNT_W'(NULL_LINK);
					pool_avail           = pool_avail - 1'b1;
				end
			end
			OP_FREE: begin
				if (!pool_return(r.handle))
					o.status = STAT_OVERFREE;
			end
			OP_PUSH: begin
				if (ring_fill >= RING_N) begin
					if (r.drop_mode == DROP_OLDEST) begin
						oldest = ring_slot[ring_front];
						if (pool_avail >= POOL_N || oldest >= POOL_N) begin
							o.status = STAT_OVERFREE;
						end else begin
							void'(ring_take());
							void'(pool_return(oldest));
							ring_append(r.handle);
						end
					end else if (r.drop_mode == DROP_INCOMING) begin
						if (!pool_return(r.handle))
							o.status = STAT_OVERFREE;
					end else begin
						o.status = STAT_OVERFLOW;
					end
				end else begin
					ring_append(r.handle);
				end
			end
			OP_PEEK: begin
				if (ring_fill == 0)
					o.status = STAT_EMPTY;
				else
					o.result_handle = ring_slot[ring_front];
			end
			OP_POP: begin
				if (ring_fill == 0)
					o.status = STAT_EMPTY;
				else
					o.result_handle = ring_take();
			end
			default: begin
			end
		endcase
		o.free_count  = pool_avail;
		o.queue_count = ring_fill;
		return o;
	endfunction

	function automatic pool_req_t make_req(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
		logic [MODE_W-1:0] m);
		pool_req_t r;
		r.operation = op;
		r.handle    = h;
		r.drop_mode = m;
		return r;
	endfunction

	function automatic pool_req_t random_req(op_mix_t mix);
		pool_req_t r;
		int        roll;
		int        w_alloc;
		int        w_free;
		int        w_push;
		int        w_pop;
		case (mix)
			MIX_ALLOC: begin
				w_alloc = 60; w_free = 10; w_push = 12; w_pop = 10;
			end
			MIX_FREE: begin
				w_alloc = 10; w_free = 60; w_push = 12; w_pop = 10;
			end
			MIX_PUSH: begin
				w_alloc = 15; w_free = 10; w_push = 55; w_pop = 10;
			end
			MIX_POP: begin
				w_alloc = 10; w_free = 10; w_push = 15; w_pop = 55;
			end
			default: begin
				w_alloc = 20; w_free = 20; w_push = 20; w_pop = 20;
			end
		endcase
		roll        = $urandom_range(0, 99);
		r.handle    = HANDLE_W'($urandom_range(0, 15));
		r.drop_mode = MODE_W'($urandom_range(0, 3));
		if (roll < 3)
			r.operation = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
		else if (roll < 3 + w_alloc)
			r.operation = OP_ALLOC;
		else if (roll < 3 + w_alloc + w_free)
			r.operation = OP_FREE;
		else if (roll < 3 + w_alloc + w_free + w_push)
			r.operation = OP_PUSH;
		else if (roll < 3 + w_alloc + w_free + w_push + w_pop)
			r.operation = OP_POP;
		else
			r.operation = OP_PEEK;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

	// request driver
	always @(negedge clk) begin : cmd_driver
		bit offer;
		bit drain_hold;
		offer = 1'b0;
		drain_hold = (accepted_total == directed_count || accepted_total == DRAIN_POINT) &&
			expected_rsps.size() != 0;
		if (!arst_n) begin
			offer = 1'b0;
		end else if (cmd_ch.valid && !cmd_taken) begin
			offer = 1'b1;
		end else begin
			cmd_taken = 1'b0;
			if (pending_reqs.size() != 0 && !drain_hold &&
				((accepted_total >= CALM_TX_FIRST && accepted_total < CALM_TX_LAST) ||
				$urandom_range(0, 99) >= IDLE_PCT)) begin
				offer = 1'b1;
				cmd_ch.operation <= pending_reqs[0].operation;
				cmd_ch.handle    <= pending_reqs[0].handle;
				cmd_ch.drop_mode <= pending_reqs[0].drop_mode;
			end
		end
		cmd_ch.valid <= offer;
	end

	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			expected_rsps.push_back(apply_pool_op(pending_reqs[0]));
			void'(pending_reqs.pop_front());
			accepted_total = accepted_total + 1;
			cmd_taken = 1'b1;
		end
	end

	// response ready, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (results_seen == LONG_STALL_AT && !long_stall_done) begin
			long_stall_done = 1'b1;
			stall_left = LONG_STALL - 1;
			rsp_ch.ready <= 1'b0;
		end else if (results_seen >= CALM_RX_FIRST && results_seen < CALM_RX_LAST) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : rsp_monitor
		pool_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen = results_seen + 1;
			if (expected_rsps.size() == 0) begin
				$error("response with no request outstanding");
				errors = errors + 1;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					errors = errors + 1;
				end
				if (rsp_ch.result_handle !== want.result_handle) begin
					$error("result_handle: expected %0d, got %0d", want.result_handle,
						rsp_ch.result_handle);
					errors = errors + 1;
				end
				if (rsp_ch.pool_free_count !== want.free_count) begin
					$error("pool_free_count: expected %0d, got %0d", want.free_count,
						rsp_ch.pool_free_count);
					errors = errors + 1;
				end
				if (rsp_ch.queue_count !== want.queue_count) begin
					$error("queue_count: expected %0d, got %0d", want.queue_count,
						rsp_ch.queue_count);
					errors = errors + 1;
				end
			end
		end
	end

	initial begin
		int      made;
		int      chunk;
		op_mix_t mix;
		int      waited;

		accepted_total  = 0;
		results_seen    = 0;
		errors          = 0;
		cmd_taken       = 1'b0;
		stall_left      = 0;
		long_stall_done = 1'b0;
		arst_n          = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.operation = '0;
		cmd_ch.handle    = '0;
		cmd_ch.drop_mode = '0;
		rsp_ch.ready     = 1'b0;
		reset_shadow();

		// empty ring, overfree of a full pool, then fill the ring with edge handles
		pending_reqs.push_back(make_req(OP_POP, 4'd0, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_PEEK, 4'd15, DROP_SPARE));
		pending_reqs.push_back(make_req(OP_FREE, 4'd15, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd0, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd15, DROP_SPARE));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd5, DROP_OLDEST));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd10, DROP_INCOMING));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd3, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd12, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd7, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd8, DROP_REPORT));
		// full ring: every drop mode, first with the pool full
		pending_reqs.push_back(make_req(OP_PUSH, 4'd9, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd9, DROP_SPARE));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd9, DROP_OLDEST));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd9, DROP_INCOMING));
		pending_reqs.push_back(make_req(OP_ALLOC, 4'd6, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd1, DROP_OLDEST));
		pending_reqs.push_back(make_req(OP_ALLOC, 4'd0, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_PUSH, 4'd15, DROP_INCOMING));
		pending_reqs.push_back(make_req(OP_PEEK, 4'd0, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_POP, 4'd0, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_SPARE_A, 4'd15, DROP_SPARE));
		pending_reqs.push_back(make_req(OP_SPARE_B, 4'd0, DROP_REPORT));
		pending_reqs.push_back(make_req(OP_SPARE_C, 4'd15, DROP_SPARE));
		directed_count = pending_reqs.size();

		// random phases, each leaning on one kind of request so the pool and
		// the ring swing between empty and full
		made = 0;
		while (made < RANDOM_ITEMS) begin
			chunk = $urandom_range(20, 80);
			mix   = op_mix_t'($urandom_range(MIX_EVEN, MIX_POP));
			for (int i = 0; i < chunk && made < RANDOM_ITEMS; i++) begin
				pending_reqs.push_back(random_req(mix));
				made = made + 1;
			end
		end
		total_items = pending_reqs.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_total < total_items)
			@(posedge clk);
		waited = 0;
		while (expected_rsps.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited = waited + 1;
		end
		repeat (20) @(posedge clk);

		if (expected_rsps.size() != 0) begin
			$error("%0d responses never arrived", expected_rsps.size());
			errors = errors + 1;
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
hdl/ppdq_pkg.sv
hdl/ppdq_cmd_if.sv
hdl/ppdq_rsp_if.sv
hdl/ppdq_link_ram.sv
hdl/ppdq_slot_ram.sv
hdl/packet_pool_with_drop_queue_unit.sv
test/packet_pool_with_drop_queue_unit_test.sv
